// File: src/mpw_pkg.sv
`default_nettype none
package mpw_pkg;

  localparam int STORE_DEPTH  = 32768;
  localparam int MAX_DIM      = 256;
  localparam int MAX_KERNEL   = 8;
  localparam int MAX_CHANNELS = 512;

  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int CHAN_W   = 10;
  localparam int DIM_W    = 9;
  localparam int KER_W    = 4;
  localparam int PLANE_W  = 9;
  localparam int POS_W    = 8;
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  localparam int PSIZE_W = 2 * DIM_W;
  localparam int ROWW_W  = POS_W + DIM_W;
  localparam int ORG_W   = POS_W + KER_W;
  localparam int TAP_W   = ORG_W + 1;
  localparam int TRW_W   = ORG_W + DIM_W;
  localparam int WIDE_W  = PLANE_W + PSIZE_W + 1;

  localparam logic signed [SAMPLE_W-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_CHANNELS  = 3'd0,
    REG_HEIGHT_IN     = 3'd1,
    REG_WIDTH_IN      = 3'd2,
    REG_HEIGHT_OUT    = 3'd3,
    REG_WIDTH_OUT     = 3'd4,
    REG_KERNEL_WIDTH  = 3'd5,
    REG_KERNEL_HEIGHT = 3'd6,
    REG_STRIDE        = 3'd7
  } mpw_reg_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL1  = 6'b000010,
    S_MUL2  = 6'b000100,
    S_CHK   = 6'b001000,
    S_TAP   = 6'b010000,
    S_DRAIN = 6'b100000
  } mpw_state_e;

  typedef struct packed {
    logic                       we;
    logic                       re;
    logic                       ok;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] wdata;
  } mpw_mem_req_t;

endpackage
`default_nettype wire

// File: src/mpw_store.sv
`default_nettype none
module mpw_store
  import mpw_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire mpw_mem_req_t               req_i,
  output logic                            tap_valid_o,
  output logic signed [SAMPLE_W-1:0]      tap_o
);

  logic [SAMPLE_W-1:0] mem_q [STORE_DEPTH];
  logic [SAMPLE_W-1:0] rd_q;
  logic                rd_valid_q;
  logic                rd_ok_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      rd_ok_q    <= 1'b0;
    end else begin
      rd_valid_q <= req_i.re;
      rd_ok_q    <= req_i.re & req_i.ok;
    end
  end

  // taps outside the plane read as zero
  assign tap_valid_o = rd_valid_q;
  assign tap_o       = rd_ok_q ? signed'(rd_q) : '0;

endmodule
`default_nettype wire

// File: src/max_pool_window.sv
// max_pool_window: 2D max pooling over a stored feature map.
//
// Input channel: start_i with req_type_i, plane_i, row_i, col_i, sample_i.
// An item transfers on a rising edge with start_i high and busy_o low.
// A write (req_type_i = 0) stores one sample and gives no result; busy_o
// stays high while it passes S_MUL1, S_MUL2 and S_CHK, and no item transfers meanwhile.
// A query (req_type_i = 1) gives one result on max_value_o / error_o,
// marked by done_o for exactly one cycle.
// A query passes S_MUL1, S_MUL2 and S_CHK and then scans the window in
// S_TAP and S_DRAIN; an error or an empty window ends in S_CHK. busy_o falls
// as done_o rises; the next item can transfer on the edge taking the result.
// One window tap is read per cycle from the single-port sample memory,
// which sets the query time. One item is in flight at a time.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Write registers only while the block is idle.
// Reset restores the register defaults and empties the pipeline; the
// sample memory is not cleared and entries are undefined until written.
// The receiver cannot stall: results must be taken on the done_o cycle.
`default_nettype none
module max_pool_window
  import mpw_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]        cfg_data_i,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        req_type_i,
  input  wire logic [PLANE_W-1:0]          plane_i,
  input  wire logic [POS_W-1:0]            row_i,
  input  wire logic [POS_W-1:0]            col_i,
  input  wire logic signed [SAMPLE_W-1:0]  sample_i,
  output logic                             done_o,
  output logic signed [SAMPLE_W-1:0]       max_value_o,
  output logic                             error_o
);

  // config registers
  logic [CHAN_W-1:0] chans_q;
  logic [DIM_W-1:0]  hin_q, win_q, hout_q, wout_q;
  logic [KER_W-1:0]  kw_q, kh_q, stride_q;

  logic [CHAN_W-1:0] chans;
  logic [DIM_W-1:0]  hin, win, hout, wout;
  logic [KER_W-1:0]  kw, kh;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chans_q  <= CHAN_W'(1);
      hin_q    <= DIM_W'(1);
      win_q    <= DIM_W'(1);
      hout_q   <= DIM_W'(1);
      wout_q   <= DIM_W'(1);
      kw_q     <= KER_W'(2);
      kh_q     <= KER_W'(2);
      stride_q <= KER_W'(2);
    end else if (cfg_valid_i) begin
      case (mpw_reg_e'(cfg_index_i))
        REG_NUM_CHANNELS:  chans_q  <= cfg_data_i[CHAN_W-1:0];
        REG_HEIGHT_IN:     hin_q    <= cfg_data_i[DIM_W-1:0];
        REG_WIDTH_IN:      win_q    <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT_OUT:    hout_q   <= cfg_data_i[DIM_W-1:0];
        REG_WIDTH_OUT:     wout_q   <= cfg_data_i[DIM_W-1:0];
        REG_KERNEL_WIDTH:  kw_q     <= cfg_data_i[KER_W-1:0];
        REG_KERNEL_HEIGHT: kh_q     <= cfg_data_i[KER_W-1:0];
        REG_STRIDE:        stride_q <= cfg_data_i[KER_W-1:0];
        default: ;
      endcase
    end
  end

  assign chans = (chans_q > CHAN_W'(MAX_CHANNELS)) ? CHAN_W'(MAX_CHANNELS) : chans_q;
  assign hin   = (hin_q  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : hin_q;
  assign win   = (win_q  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : win_q;
  assign hout  = (hout_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : hout_q;
  assign wout  = (wout_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : wout_q;
  assign kw    = (kw_q > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : kw_q;
  assign kh    = (kh_q > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : kh_q;

  // sequencer
  mpw_state_e state_q, state_d;
  logic [KER_W-1:0]  ii_q, ii_d, jj_q, jj_d;
  logic [TAP_W-1:0]  tr_q, tr_d, tc_q, tc_d;
  logic [WIDE_W-1:0] row_addr_q, row_addr_d;
  logic              done_q, done_d;
  logic              err_q, err_d;
  logic signed [SAMPLE_W-1:0] max_q, max_d;
  logic signed [SAMPLE_W-1:0] best_q, best_d;

  // item and geometry payload
  logic                       req_q;
  logic [PLANE_W-1:0]         pl_q;
  logic [POS_W-1:0]           r_q, c_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [PSIZE_W-1:0]         psize_q;
  logic [ROWW_W-1:0]          rw_q;
  logic [ORG_W-1:0]           rs_q, cs_q;
  logic [WIDE_W-1:0]          base_q;
  logic [TRW_W-1:0]           trw_q;

  logic              accept;
  logic [WIDE_W-1:0] wr_addr;
  logic              wr_ok;
  logic              q_err;
  logic              tap_inb;
  logic [WIDE_W-1:0] tap_addr;
  logic              tap_ok;
  logic              tap_valid;
  logic signed [SAMPLE_W-1:0] tap;
  logic signed [SAMPLE_W-1:0] best_upd;
  mpw_mem_req_t      mem_req;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i & ~busy_o;

  assign wr_addr = base_q + WIDE_W'(rw_q) + WIDE_W'(c_q);
  assign wr_ok   = (CHAN_W'(pl_q) < chans) && (DIM_W'(r_q) < hin) && (DIM_W'(c_q) < win)
                   && (wr_addr < WIDE_W'(STORE_DEPTH));
  assign q_err   = (CHAN_W'(pl_q) >= chans) || (DIM_W'(r_q) >= hout) || (DIM_W'(c_q) >= wout)
                   || ((base_q + WIDE_W'(psize_q)) > WIDE_W'(STORE_DEPTH));

  assign tap_inb  = (tr_q < TAP_W'(hin)) && (tc_q < TAP_W'(win));
  assign tap_addr = row_addr_q + WIDE_W'(tc_q);
  assign tap_ok   = tap_inb && (tap_addr < WIDE_W'(STORE_DEPTH));

  assign best_upd = (tap_valid && (tap > best_q)) ? tap : best_q;

  always_comb begin
    mem_req       = '0;
    mem_req.wdata = sample_q;
    if (state_q == S_CHK) begin
      mem_req.we   = ~req_q & wr_ok;
      mem_req.addr = wr_addr[ADDR_W-1:0];
    end else begin
      mem_req.re   = (state_q == S_TAP);
      mem_req.ok   = tap_ok;
      mem_req.addr = tap_addr[ADDR_W-1:0];
    end
  end

  mpw_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .tap_valid_o (tap_valid),
    .tap_o       (tap)
  );

  always_comb begin
    state_d    = state_q;
    ii_d       = ii_q;
    jj_d       = jj_q;
    tr_d       = tr_q;
    tc_d       = tc_q;
    row_addr_d = row_addr_q;
    best_d     = best_upd;
    done_d     = 1'b0;
    err_d      = err_q;
    max_d      = max_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_MUL1;
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_CHK;
      S_CHK: begin
        state_d = S_IDLE;
        if (req_q) begin
          if (q_err) begin
            done_d = 1'b1;
            err_d  = 1'b1;
            max_d  = '0;
          end else if (kw == '0 || kh == '0) begin
            done_d = 1'b1;
            err_d  = 1'b0;
            max_d  = MIN_SAMPLE;
          end else begin
            state_d    = S_TAP;
            ii_d       = '0;
            jj_d       = '0;
            tr_d       = TAP_W'(rs_q);
            tc_d       = TAP_W'(cs_q);
            row_addr_d = base_q + WIDE_W'(trw_q);
            best_d     = MIN_SAMPLE;
          end
        end
      end
      S_TAP: begin
        if (jj_q == kw - KER_W'(1)) begin
          jj_d       = '0;
          tc_d       = TAP_W'(cs_q);
          ii_d       = ii_q + KER_W'(1);
          tr_d       = tr_q + TAP_W'(1);
          row_addr_d = row_addr_q + WIDE_W'(win);
          if (ii_q == kh - KER_W'(1)) state_d = S_DRAIN;
        end else begin
          jj_d = jj_q + KER_W'(1);
          tc_d = tc_q + TAP_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        err_d   = 1'b0;
        max_d   = best_upd;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ii_q       <= ii_d;
    jj_q       <= jj_d;
    tr_q       <= tr_d;
    tc_q       <= tc_d;
    row_addr_q <= row_addr_d;
    best_q     <= best_d;
    err_q      <= err_d;
    max_q      <= max_d;
    if (accept) begin
      req_q    <= req_type_i;
      pl_q     <= plane_i;
      r_q      <= row_i;
      c_q      <= col_i;
      sample_q <= sample_i;
    end
    if (state_q == S_MUL1) begin
      psize_q <= PSIZE_W'(hin * win);
      rw_q    <= ROWW_W'(r_q * win);
      rs_q    <= ORG_W'(r_q * stride_q);
      cs_q    <= ORG_W'(c_q * stride_q);
    end
    if (state_q == S_MUL2) begin
      base_q <= WIDE_W'(pl_q * psize_q);
      trw_q  <= TRW_W'(rs_q * win);
    end
  end

  assign done_o      = done_q;
  assign error_o     = err_q;
  assign max_value_o = max_q;

`ifndef SYNTHESIS
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held longer than one cycle");
  a_strobe_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without an item in flight");
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_o) |-> (max_value_o == '0)) else $error("error result not zero");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("accepted item did not start");
  a_tap_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_valid |-> (state_q == S_TAP || state_q == S_DRAIN))
    else $error("tap data arrived outside the window scan");
`endif

endmodule
`default_nettype wire
